>>> src/pfn_pkg.sv
// package for the polygon face normal block
// shared widths, status codes and the front-to-back queue entry type
package pfn_pkg;

    localparam int MaxVertices = 64;
    localparam int CoordBits = 16;
    localparam int NormFracBits = 14;
    localparam int CntBits = $clog2(MaxVertices + 1);
    localparam int SumBits = 2 * CoordBits + 2 + $clog2(MaxVertices + 2) + 1;
    localparam int MagBits = 30;
    localparam int QBits = NormFracBits + 1;
    localparam int LenBits = 2 * MagBits + 2;
    localparam int ProdBits = 2 * QBits + LenBits;
    localparam int QueueDepth = 4;
    localparam int QPtrBits = $clog2(QueueDepth);

    localparam logic [1:0] StatusOk = 2'd0;
    localparam logic [1:0] StatusFew = 2'd1;
    localparam logic [1:0] StatusZero = 2'd2;
    localparam logic [1:0] StatusMany = 2'd3;

    typedef logic signed [CoordBits-1:0] coord_t;
    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    // one corner to add, a closing marker, or both at once
    typedef struct packed {
        logic close;
        logic corner;
        logic [1:0] status;
        vec_t a;
        vec_t b;
        vec_t c;
    } job_t;

endpackage

>>> src/pfn_front.sv
// front part: takes vertices, tracks first/previous vertices and counts,
// emits corner and close jobs into the queue; depends on pfn_pkg
module pfn_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  pfn_pkg::vec_t  in_vtx,
    input  logic           in_last,
    output logic           job_valid,
    input  logic           job_ready,
    output pfn_pkg::job_t  job
);
    import pfn_pkg::*;

    typedef enum logic [2:0] {
        F_RUN   = 3'b001,
        F_WRAP1 = 3'b010,
        F_WRAP2 = 3'b100
    } fstate_t;

    fstate_t state_reg, state_next;
    vec_t f0_reg, f1_reg, p0_reg, p1_reg;
    vec_t f0_next, f1_next, p0_next, p1_next;
    logic [CntBits-1:0] cnt_reg, cnt_next;
    logic ovf_reg, ovf_next;
    logic [1:0] cls_stat;

    assign in_ready = (state_reg == F_RUN) && job_ready;

    always_comb begin
        state_next = state_reg;
        f0_next = f0_reg;
        f1_next = f1_reg;
        p0_next = p0_reg;
        p1_next = p1_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        job_valid = 1'b0;
        job = '0;
        cls_stat = StatusOk;
        unique case (state_reg)
            F_RUN: begin
                if (in_valid && job_ready) begin
                    if (cnt_reg >= CntBits'(MaxVertices)) begin
                        ovf_next = 1'b1;
                    end else begin
                        if (cnt_reg == '0) f0_next = in_vtx;
                        if (cnt_reg == CntBits'(1)) f1_next = in_vtx;
                        if (cnt_reg >= CntBits'(2)) begin
                            job_valid = 1'b1;
                            job.corner = 1'b1;
                            job.a = p0_reg;
                            job.b = p1_reg;
                            job.c = in_vtx;
                        end
                        p0_next = p1_reg;
                        p1_next = in_vtx;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (in_last) begin
                        if (ovf_next) cls_stat = StatusMany;
                        else if (cnt_next < CntBits'(3)) cls_stat = StatusFew;
                        if (cls_stat != StatusOk) begin
                            // no corner goes with this close: the back part drops the sum
                            job_valid = 1'b1;
                            job.close = 1'b1;
                            job.status = cls_stat;
                            cnt_next = '0;
                            ovf_next = 1'b0;
                        end else begin
                            state_next = F_WRAP1;
                        end
                    end
                end
            end
            F_WRAP1: begin
                job_valid = 1'b1;
                job.corner = 1'b1;
                job.a = p0_reg;
                job.b = p1_reg;
                job.c = f0_reg;
                if (job_ready) state_next = F_WRAP2;
            end
            F_WRAP2: begin
                job_valid = 1'b1;
                job.corner = 1'b1;
                job.close = 1'b1;
                job.status = StatusOk;
                job.a = p1_reg;
                job.b = f0_reg;
                job.c = f1_reg;
                if (job_ready) begin
                    state_next = F_RUN;
                    cnt_next = '0;
                    ovf_next = 1'b0;
                end
            end
            default: state_next = F_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_RUN;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
        f0_reg <= f0_next;
        f1_reg <= f1_next;
        p0_reg <= p0_next;
        p1_reg <= p1_next;
    end

`ifndef ASSERT_OFF
    a_wrap_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != F_RUN |-> !in_ready)
        else $error("vertex taken during wrap");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CntBits'(MaxVertices))
        else $error("vertex count out of range");
    a_wrap_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == F_WRAP1 && job_ready |=> state_reg == F_WRAP2)
        else $error("wrap sequence broken");
`endif

endmodule

>>> src/pfn_queue.sv
// small job fifo between front and back parts
// depends on pfn_pkg
module pfn_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  pfn_pkg::job_t  wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output pfn_pkg::job_t  rd_data
);
    import pfn_pkg::*;

    job_t mem_reg [QueueDepth];
    logic [QPtrBits-1:0] wp_reg, rp_reg;
    logic [QPtrBits:0] cnt_reg;
    logic wr_fire, rd_fire;

    assign wr_ready = cnt_reg != (QPtrBits+1)'(QueueDepth);
    assign rd_valid = cnt_reg != '0;
    assign rd_data = mem_reg[rp_reg];
    assign wr_fire = wr_valid && wr_ready;
    assign rd_fire = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_fire) wp_reg <= wp_reg + 1'b1;
            if (rd_fire) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPtrBits+1)'(wr_fire) - (QPtrBits+1)'(rd_fire);
        end
        if (wr_fire) mem_reg[wp_reg] <= wr_data;
    end

`ifndef ASSERT_OFF
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[QPtrBits-1:0] == QPtrBits'(wp_reg - rp_reg))
        else $error("queue pointers disagree with count");
    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (QPtrBits+1)'(QueueDepth))
        else $error("queue overfilled");
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_fire && !rd_fire |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a write");
`endif

endmodule

>>> src/pfn_back.sv
// back part: accumulates corner cross products, then normalizes once
// per polygon with a bit-serial search per component; depends on pfn_pkg
module pfn_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           job_valid,
    output logic           job_ready,
    input  pfn_pkg::job_t  job,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [15:0]    out_nx,
    output logic [15:0]    out_ny,
    output logic [15:0]    out_nz,
    output logic [1:0]     out_status
);
    import pfn_pkg::*;

    typedef enum logic [10:0] {
        B_IDLE  = 11'b00000000001,
        B_EDGE  = 11'b00000000010,
        B_MUL   = 11'b00000000100,
        B_ACC   = 11'b00000001000,
        B_SHIFT = 11'b00000010000,
        B_SQ    = 11'b00000100000,
        B_SRCH  = 11'b00001000000,
        B_MLO   = 11'b00010000000,
        B_MHI   = 11'b00100000000,
        B_CMP   = 11'b01000000000,
        B_OUT   = 11'b10000000000
    } bstate_t;

    localparam int EBits = CoordBits + 1;
    localparam int PBits = 2 * EBits;
    localparam int BBits = $clog2(QBits + 1);
    localparam int HalfBits = LenBits / 2;

    bstate_t state_reg;
    logic signed [EBits-1:0] e1_reg [3];
    logic signed [EBits-1:0] e2_reg [3];
    logic signed [PBits-1:0] pa_reg [3];
    logic signed [PBits-1:0] pb_reg [3];
    logic signed [SumBits-1:0] sum_reg [3];
    logic [SumBits-1:0] mag_reg [3];
    logic [2:0] neg_reg;
    logic close_reg;
    logic [1:0] stat_reg;
    logic [1:0] sq_reg;
    logic [LenBits-1:0] len_reg;
    logic [1:0] comp_reg;
    logic [BBits-1:0] bit_reg;
    logic [QBits-1:0] q_reg;
    logic [QBits-1:0] trial_reg;
    logic [2*QBits-1:0] tsq_reg;
    logic [ProdBits-1:0] rhs_reg;
    logic [ProdBits-1:0] prod_reg;
    logic [QBits-1:0] res_reg [3];
    logic [MagBits-1:0] m_cur;
    logic [2*MagBits-1:0] msq;
    logic [QBits-1:0] trial;
    logic [SumBits-1:0] mx;
    logic [HalfBits-1:0] len_half;
    logic [2*QBits+HalfBits-1:0] pp;
    logic take;

    assign job_ready = state_reg == B_IDLE;
    assign out_valid = state_reg == B_OUT;
    assign out_status = stat_reg;
    assign out_nx = 16'(neg_reg[0] ? -$signed({1'b0, res_reg[0]}) : $signed({1'b0, res_reg[0]}));
    assign out_ny = 16'(neg_reg[1] ? -$signed({1'b0, res_reg[1]}) : $signed({1'b0, res_reg[1]}));
    assign out_nz = 16'(neg_reg[2] ? -$signed({1'b0, res_reg[2]}) : $signed({1'b0, res_reg[2]}));

    assign m_cur = mag_reg[comp_reg][MagBits-1:0];
    assign msq = m_cur * m_cur;
    assign trial = q_reg | (QBits'(1) << bit_reg);
    assign mx = (mag_reg[0] | mag_reg[1] | mag_reg[2]);

    // trial^2 * len is built from two half-width partial products
    assign len_half = (state_reg == B_MLO) ? len_reg[HalfBits-1:0]
                                           : len_reg[LenBits-1:HalfBits];
    assign pp = tsq_reg * len_half;
    assign take = (trial_reg <= QBits'(1 << NormFracBits)) && (prod_reg <= rhs_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            for (int i = 0; i < 3; i++) sum_reg[i] <= '0;
        end else begin
            unique case (state_reg)
                B_IDLE: begin
                    if (job_valid) begin
                        close_reg <= job.close;
                        stat_reg <= job.status;
                        for (int i = 0; i < 3; i++) begin
                            res_reg[i] <= '0;
                        end
                        neg_reg <= '0;
                        if (job.corner) begin
                            e1_reg[0] <= EBits'(job.a.x) - EBits'(job.b.x);
                            e1_reg[1] <= EBits'(job.a.y) - EBits'(job.b.y);
                            e1_reg[2] <= EBits'(job.a.z) - EBits'(job.b.z);
                            e2_reg[0] <= EBits'(job.c.x) - EBits'(job.b.x);
                            e2_reg[1] <= EBits'(job.c.y) - EBits'(job.b.y);
                            e2_reg[2] <= EBits'(job.c.z) - EBits'(job.b.z);
                            state_reg <= B_MUL;
                        end else begin
                            for (int i = 0; i < 3; i++) sum_reg[i] <= '0;
                            state_reg <= B_OUT;
                        end
                    end
                end
                B_EDGE: state_reg <= B_MUL;
                B_MUL: begin
                    pa_reg[0] <= e2_reg[1] * e1_reg[2];
                    pb_reg[0] <= e2_reg[2] * e1_reg[1];
                    pa_reg[1] <= e2_reg[2] * e1_reg[0];
                    pb_reg[1] <= e2_reg[0] * e1_reg[2];
                    pa_reg[2] <= e2_reg[0] * e1_reg[1];
                    pb_reg[2] <= e2_reg[1] * e1_reg[0];
                    state_reg <= B_ACC;
                end
                B_ACC: begin
                    for (int i = 0; i < 3; i++) begin
                        sum_reg[i] <= sum_reg[i] + SumBits'(pa_reg[i]) - SumBits'(pb_reg[i]);
                    end
                    if (close_reg) state_reg <= B_SHIFT;
                    else state_reg <= B_IDLE;
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= '0;
                    end
                    sq_reg <= '0;
                end
                B_SHIFT: begin
                    // first pass loads magnitudes, then flags a zero sum or shifts until below 2^30
                    if (sq_reg == 2'd0) begin
                        for (int i = 0; i < 3; i++) begin
                            neg_reg[i] <= sum_reg[i][SumBits-1];
                            mag_reg[i] <= sum_reg[i][SumBits-1] ? SumBits'(-sum_reg[i])
                                                                : SumBits'(sum_reg[i]);
                            sum_reg[i] <= '0;
                        end
                        sq_reg <= 2'd1;
                    end else if (mx == '0) begin
                        stat_reg <= StatusZero;
                        state_reg <= B_OUT;
                    end else if (mx[SumBits-1:MagBits] != '0) begin
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                    end else begin
                        len_reg <= '0;
                        comp_reg <= '0;
                        state_reg <= B_SQ;
                    end
                end
                B_SQ: begin
                    len_reg <= len_reg + LenBits'(msq);
                    if (comp_reg == 2'd2) begin
                        comp_reg <= '0;
                        bit_reg <= BBits'(QBits - 1);
                        q_reg <= '0;
                        state_reg <= B_SRCH;
                    end else begin
                        comp_reg <= comp_reg + 1'b1;
                    end
                end
                B_SRCH: begin
                    trial_reg <= trial;
                    tsq_reg <= trial * trial;
                    rhs_reg <= ProdBits'(msq) << (2 * NormFracBits);
                    state_reg <= B_MLO;
                end
                B_MLO: begin
                    prod_reg <= ProdBits'(pp);
                    state_reg <= B_MHI;
                end
                B_MHI: begin
                    prod_reg <= prod_reg + (ProdBits'(pp) << HalfBits);
                    state_reg <= B_CMP;
                end
                B_CMP: begin
                    if (bit_reg == '0) begin
                        res_reg[comp_reg] <= take ? trial_reg : q_reg;
                        q_reg <= '0;
                        bit_reg <= BBits'(QBits - 1);
                        if (comp_reg == 2'd2) state_reg <= B_OUT;
                        else begin
                            comp_reg <= comp_reg + 1'b1;
                            state_reg <= B_SRCH;
                        end
                    end else begin
                        if (take) q_reg <= trial_reg;
                        bit_reg <= bit_reg - 1'b1;
                        state_reg <= B_SRCH;
                    end
                end
                B_OUT: if (out_ready) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_status != StatusOk |-> out_nx == '0 && out_ny == '0 && out_nz == '0)
        else $error("nonzero normal with error status");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != B_IDLE |-> !job_ready)
        else $error("job taken while busy");
`endif

endmodule

>>> src/polygon_face_normal.sv
// top level of the polygon face normal block: front, queue, back
// depends on pfn_pkg, pfn_front, pfn_queue, pfn_back
//
// channel  dir  tdata (low bit up)          tuser/tlast
// s_axis   in   px[15:0] py[31:16] pz[47:32] tlast = last_vertex
// m_axis   out  nx ny nz status[49:48]       none
//
// vertices enter one per cycle until the 4-entry job queue fills; the back
// part then drains one corner per idle, multiply, accumulate pass, which
// sets the sustained rate. closing a polygon holds the input in its wrap
// states; normalizing shifts and squares the magnitudes and then searches
// each component bit by bit. reset is synchronous; a stalled result holds
// the back part and, once the queue is full, s_tready.
module polygon_face_normal (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // px, py, pz
    input  logic        s_tlast,   // last_vertex
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // nx, ny, nz, status, zero pad
);
    import pfn_pkg::*;

    vec_t vtx;
    job_t fj, bj;
    logic fj_valid, fj_ready, bj_valid, bj_ready;
    logic [15:0] nx, ny, nz;
    logic [1:0] status;

    assign vtx.x = s_tdata[15:0];
    assign vtx.y = s_tdata[31:16];
    assign vtx.z = s_tdata[47:32];
    assign m_tdata = {6'd0, status, nz, ny, nx};

    pfn_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_vtx(vtx), .in_last(s_tlast),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    pfn_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
    );

    pfn_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_nx(nx), .out_ny(ny), .out_nz(nz), .out_status(status)
    );

endmodule

>>> sim/tb_top.sv
// testbench for polygon_face_normal: streams polygons and checks unit normals
// depends on pfn_pkg and the polygon_face_normal rtl; predictor lives in pfn_scoreboard
`timescale 1ns / 1ps

module tb_top;
    import pfn_pkg::*;

    class pfn_scoreboard;
        longint first_v[2][3];
        longint prev_v[2][3];
        longint sum_v[3];
        int vcount;
        bit overflow;
        logic [55:0] expected_q[$];
        int errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 3; j++) begin
                    first_v[i][j] = 0;
                    prev_v[i][j] = 0;
                end
            for (int j = 0; j < 3; j++) sum_v[j] = 0;
            vcount = 0;
            overflow = 0;
        endfunction

        // adds (c-b) x (a-b) to the running sum
        function void add_corner(longint a[3], longint b[3], longint c[3]);
            longint e1[3];
            longint e2[3];
            for (int i = 0; i < 3; i++) begin
                e1[i] = a[i] - b[i];
                e2[i] = c[i] - b[i];
            end
            sum_v[0] += e2[1] * e1[2] - e2[2] * e1[1];
            sum_v[1] += e2[2] * e1[0] - e2[0] * e1[2];
            sum_v[2] += e2[0] * e1[1] - e2[1] * e1[0];
        endfunction

        // largest q <= 2^F with q^2 * len2 <= m^2 * 2^2F
        function longint unsigned unit_component(longint unsigned m, longint unsigned len2);
            logic [127:0] lhs;
            logic [127:0] rhs;
            longint unsigned lo;
            longint unsigned hi;
            longint unsigned mid;
            lhs = (128'(m) * 128'(m)) << (2 * NormFracBits);
            lo = 0;
            hi = 64'd1 << NormFracBits;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                rhs = 128'(mid * mid) * 128'(len2);
                if (rhs <= lhs) lo = mid;
                else hi = mid - 1;
            end
            return lo;
        endfunction

        function void note_vertex(logic [47:0] data, logic last);
            longint v[3];
            logic [1:0] st;
            logic [15:0] res[3];
            longint unsigned mag[3];
            longint unsigned mx;
            longint unsigned len2;
            int k;
            longint unsigned q;
            v[0] = longint'($signed(data[15:0]));
            v[1] = longint'($signed(data[31:16]));
            v[2] = longint'($signed(data[47:32]));
            if (vcount >= MaxVertices) begin
                overflow = 1;
            end else begin
                if (vcount < 2) first_v[vcount] = v;
                if (vcount >= 2) add_corner(prev_v[0], prev_v[1], v);
                prev_v[0] = prev_v[1];
                prev_v[1] = v;
                vcount++;
            end
            if (!last) return;
            st = StatusOk;
            for (int j = 0; j < 3; j++) res[j] = '0;
            if (overflow) begin
                st = StatusMany;
            end else if (vcount < 3) begin
                st = StatusFew;
            end else begin
                add_corner(prev_v[0], prev_v[1], first_v[0]);
                add_corner(prev_v[1], first_v[0], first_v[1]);
                mx = 0;
                for (int j = 0; j < 3; j++) begin
                    mag[j] = sum_v[j] < 0 ? -sum_v[j] : sum_v[j];
                    if (mag[j] > mx) mx = mag[j];
                end
                if (mx == 0) begin
                    st = StatusZero;
                end else begin
                    k = 0;
                    while ((mx >> k) >= (64'd1 << 30)) k++;
                    len2 = 0;
                    for (int j = 0; j < 3; j++) begin
                        mag[j] = mag[j] >> k;
                        len2 += mag[j] * mag[j];
                    end
                    for (int j = 0; j < 3; j++) begin
                        q = unit_component(mag[j], len2);
                        res[j] = sum_v[j] < 0 ? 16'(-q) : 16'(q);
                    end
                end
            end
            expected_q.push_back({6'd0, st, res[2], res[1], res[0]});
            clear();
        endfunction

        function void check_normal(logic [55:0] got);
            logic [55:0] exp_d;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_d = expected_q.pop_front();
            if (got[15:0] !== exp_d[15:0]) begin
                $display("%0t: nx expected %0d actual %0d", $time,
                         $signed(exp_d[15:0]), $signed(got[15:0]));
                errors++;
            end
            if (got[31:16] !== exp_d[31:16]) begin
                $display("%0t: ny expected %0d actual %0d", $time,
                         $signed(exp_d[31:16]), $signed(got[31:16]));
                errors++;
            end
            if (got[47:32] !== exp_d[47:32]) begin
                $display("%0t: nz expected %0d actual %0d", $time,
                         $signed(exp_d[47:32]), $signed(got[47:32]));
                errors++;
            end
            if (got[49:48] !== exp_d[49:48]) begin
                $display("%0t: status expected %0d actual %0d", $time,
                         exp_d[49:48], got[49:48]);
                errors++;
            end
            if (got[55:50] !== 6'd0) begin
                $display("%0t: pad expected 0 actual %h", $time, got[55:50]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    pfn_scoreboard sb;
    int sent;
    bit no_idle;
    bit hold_req;

    polygon_face_normal i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold;
        m_tready = 0;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold_req && hold == 0) begin
                hold = 400;
                hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                m_tready = 0;
            end else begin
                m_tready = no_idle ? 1'b1 : ($urandom_range(99) >= 37);
            end
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) sb.check_normal(m_tdata);

    task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic last);
        while (!no_idle && $urandom_range(99) < 37) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tdata = {z, y, x};
        s_tlast = last;
        do @(posedge aclk); while (!s_tready);
        sb.note_vertex(s_tdata, s_tlast);
        sent++;
        @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(200)) - 100);
            default: return 16'($signed($urandom_range(8000)) - 4000);
        endcase
    endfunction

    task automatic send_polygon(int n, int mode);
        for (int i = 0; i < n; i++)
            send_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode), i == n - 1);
    endtask

    task automatic wait_drained();
        s_tvalid = 0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
    endtask

    initial begin
        int n;
        sb = new();
        sent = 0;
        no_idle = 0;
        hold_req = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        aresetn = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // single vertex and two vertices
        send_vertex(16'h7fff, 16'h8000, 16'h0001, 1);
        send_vertex(16'h0001, 16'h0002, 16'h0003, 0);
        send_vertex(16'h0004, 16'h0005, 16'h0006, 1);
        // triangle at the coordinate extremes
        send_vertex(16'h8000, 16'h8000, 16'h8000, 0);
        send_vertex(16'h7fff, 16'h8000, 16'h7fff, 0);
        send_vertex(16'h8000, 16'h7fff, 16'h7fff, 1);
        // all points identical gives zero normal
        repeat (3) send_vertex(16'h1234, 16'hedcb, 16'h0f0f, 0);
        send_vertex(16'h1234, 16'hedcb, 16'h0f0f, 1);
        // collinear points, also zero
        send_vertex(16'd0, 16'd0, 16'd0, 0);
        send_vertex(16'd10, 16'd20, 16'd30, 0);
        send_vertex(16'd20, 16'd40, 16'd60, 1);
        // axis-aligned square, plain triangle
        send_vertex(16'd0, 16'd0, 16'd0, 0);
        send_vertex(16'd100, 16'd0, 16'd0, 0);
        send_vertex(16'd100, 16'd100, 16'd0, 0);
        send_vertex(16'd0, 16'd100, 16'd0, 1);
        send_vertex(16'd0, 16'd0, 16'd5, 0);
        send_vertex(16'd0, 16'd7, 16'd0, 0);
        send_vertex(16'd3, 16'd0, 16'd0, 1);
        // exactly the vertex limit, then one past it
        send_polygon(MaxVertices, 0);
        send_polygon(MaxVertices + 1, 1);

        while (sent < 800) begin
            if (sent > 300 && sent < 400) no_idle = 1;
            else no_idle = 0;
            if (sent > 500 && sent < 520 && !hold_req) hold_req = 1;
            if (sent > 650 && sent < 700) wait_drained();
            case ($urandom_range(19))
                0: n = $urandom_range(2, 1);
                1: n = $urandom_range(MaxVertices + 6, MaxVertices - 2);
                default: n = $urandom_range(12, 3);
            endcase
            send_polygon(n, $urandom_range(2));
        end
        no_idle = 0;
        wait_drained();
        repeat (400) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/pfn_pkg.sv
src/pfn_front.sv
src/pfn_queue.sv
src/pfn_back.sv
src/polygon_face_normal.sv
sim/tb_top.sv
